### design/usd_pkg.sv
// Shared types and constants for the UTF-8 sequence decoder.
`timescale 1ns / 1ps

package usd_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ILSEQ  = 2'd1,
        ST_TOOFEW = 2'd2
    } status_t;

    // Window and field sizes.
    localparam int unsigned WINDOW_BYTES = 6;
    localparam int unsigned CP_W         = 31;
    localparam int unsigned LEN_W        = 3;
    localparam int unsigned IN_DATA_W    = 56;
    localparam int unsigned OUT_DATA_W   = 40;

    // Lead byte boundaries.
    localparam logic [7:0] LEAD_2B_MIN = 8'hc2;
    localparam logic [7:0] LEAD_3B_MIN = 8'he0;
    localparam logic [7:0] LEAD_4B_MIN = 8'hf0;
    localparam logic [7:0] LEAD_5B_MIN = 8'hf8;
    localparam logic [7:0] LEAD_6B_MIN = 8'hfc;
    localparam logic [7:0] LEAD_BAD    = 8'hfe;

    // Lowest second byte allowed after the shortest lead of each length.
    localparam logic [7:0] MIN_SECOND_3B  = 8'ha0;
    localparam logic [7:0] MIN_SECOND_4B  = 8'h90;
    localparam logic [7:0] MIN_SECOND_5B  = 8'h88;
    localparam logic [7:0] MIN_SECOND_6B  = 8'h84;
    localparam logic [7:0] MIN_SECOND_ANY = 8'h80;

    // What the lead byte tells about the sequence.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [6:0]       payload;
        logic [7:0]       min_second;
        logic             illegal;
    } lead_info_t;

endpackage

### design/usd_lead_classifier.sv
// Lead byte classifier: sequence length, payload bits and overlong bound.
`timescale 1ns / 1ps

module usd_lead_classifier
    import usd_pkg::*;
(
    input  logic [7:0] lead_byte,
    output lead_info_t info
);

    // Decode ranges in ascending order of the lead byte.
    always_comb
    begin
        info            = '0;
        info.min_second = MIN_SECOND_ANY;
        priority if (lead_byte[7] == 1'b0)
        begin
            info.len        = 3'd1;
            info.payload    = lead_byte[6:0];
            info.min_second = 8'h00;
        end
        else if (lead_byte < LEAD_2B_MIN)
        begin
            info.illegal = 1'b1;
        end
        else if (lead_byte < LEAD_3B_MIN)
        begin
            info.len     = 3'd2;
            info.payload = {2'b00, lead_byte[4:0]};
        end
        else if (lead_byte < LEAD_4B_MIN)
        begin
            info.len     = 3'd3;
            info.payload = {3'b000, lead_byte[3:0]};
            if (lead_byte == LEAD_3B_MIN)
            begin
                info.min_second = MIN_SECOND_3B;
            end
        end
        else if (lead_byte < LEAD_5B_MIN)
        begin
            info.len     = 3'd4;
            info.payload = {4'b0000, lead_byte[2:0]};
            if (lead_byte == LEAD_4B_MIN)
            begin
                info.min_second = MIN_SECOND_4B;
            end
        end
        else if (lead_byte < LEAD_6B_MIN)
        begin
            info.len     = 3'd5;
            info.payload = {5'b00000, lead_byte[1:0]};
            if (lead_byte == LEAD_5B_MIN)
            begin
                info.min_second = MIN_SECOND_5B;
            end
        end
        else if (lead_byte < LEAD_BAD)
        begin
            info.len     = 3'd6;
            info.payload = {6'b000000, lead_byte[0]};
            if (lead_byte == LEAD_6B_MIN)
            begin
                info.min_second = MIN_SECOND_6B;
            end
        end
        else
        begin
            info.illegal = 1'b1;
        end
    end

endmodule

### design/utf8_sequence_decoder_unit.sv
// Top level of the UTF-8 sequence decoder: three-stage pipeline.
`timescale 1ns / 1ps
//
// Decodes the UTF-8 sequence (legacy one- to six-byte forms) that starts
// at the first byte of a six-byte window into a 31-bit code point.
// Input channel s_*: one word per window, holding six bytes and a count of
// valid bytes (counts above six act as six). Output channel m_*: one word
// per input word, in order, with the code point, the bytes consumed and a
// status in m_tuser (ok, illegal sequence, too few bytes). On any error the
// code point and byte count are zero.
// A word accepted on s_* passes through three register stages (lead
// classification, continuation check and assembly, result formatting),
// each with its own valid bit; m_tvalid is the valid bit of the last.
// Throughput: one word per cycle while the receiver does not stall.
// When the receiver stalls, the output stage holds its word and the stages
// behind it keep filling until every stage is full; only then does
// s_tready drop. No word is lost or repeated.
// Reset empties all stages at once; s_tready is high right after reset.
//

module utf8_sequence_decoder_unit
    import usd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // lead_byte[7:0], second_byte[15:8], third_byte[23:16], fourth_byte[31:24],
    // fifth_byte[39:32], sixth_byte[47:40], available_bytes[50:48], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // code_point[30:0], bytes_consumed[33:31], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]            m_tuser
);

    // Unpacked input fields.
    logic [7:0]       lead_byte;
    logic [7:0]       in_bytes [1:WINDOW_BYTES-1];
    logic [2:0]       available_bytes;
    logic [2:0]       avail_sat;
    lead_info_t       lead_info;

    // Stage control.
    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic             s1_ready, s2_ready, s3_ready;

    // Stage 1 registers.
    lead_info_t       s1_info_reg;
    status_t          s1_status_reg;
    status_t          s1_status_next;
    logic [7:0]       s1_bytes_reg [1:WINDOW_BYTES-1];

    // Stage 2 registers.
    status_t          s2_status_reg;
    status_t          s2_status_next;
    logic [CP_W-1:0]  s2_cp_reg;
    logic [CP_W-1:0]  s2_cp_next;
    logic [LEN_W-1:0] s2_len_reg;

    // Stage 3 (output) registers.
    status_t          s3_status_reg;
    logic [CP_W-1:0]  s3_cp_reg;
    logic [LEN_W-1:0] s3_len_reg;

    logic [5:0]       tail [1:WINDOW_BYTES-1];
    logic             cont_bad;
    logic             overlong;

    assign lead_byte       = s_tdata[7:0];
    assign available_bytes = s_tdata[50:48];
    assign avail_sat       = (available_bytes == 3'd7) ? 3'd6 : available_bytes;

    always_comb
    begin
        for (int i = 1; i < WINDOW_BYTES; i++)
        begin
            in_bytes[i] = s_tdata[8*i +: 8];
        end
    end

    // A stage takes a word when it is empty or its word moves on.
    assign s3_ready = !s3_valid_reg || m_tready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;

    usd_lead_classifier u_lead (
        .lead_byte (lead_byte),
        .info      (lead_info)
    );

    // Stage 1: early status from the count and the lead byte alone.
    always_comb
    begin
        priority if (available_bytes == 3'd0)
        begin
            s1_status_next = ST_TOOFEW;
        end
        else if (lead_info.illegal)
        begin
            s1_status_next = ST_ILSEQ;
        end
        else if (avail_sat < lead_info.len)
        begin
            s1_status_next = ST_TOOFEW;
        end
        else
        begin
            s1_status_next = ST_OK;
        end
    end

    // Stage 2: continuation bytes, overlong second byte, code point assembly.
    always_comb
    begin
        cont_bad = 1'b0;
        for (int i = 1; i < WINDOW_BYTES; i++)
        begin
            tail[i] = s1_bytes_reg[i][5:0];
            if ((LEN_W'(i) < s1_info_reg.len) && (s1_bytes_reg[i][7:6] != 2'b10))
            begin
                cont_bad = 1'b1;
            end
        end
    end

    assign overlong = (s1_info_reg.len != 3'd1) &&
                      (s1_bytes_reg[1] < s1_info_reg.min_second);

    always_comb
    begin
        unique case (s1_info_reg.len)
            3'd1:    s2_cp_next = {24'd0, s1_info_reg.payload};
            3'd2:    s2_cp_next = {20'd0, s1_info_reg.payload[4:0], tail[1]};
            3'd3:    s2_cp_next = {15'd0, s1_info_reg.payload[3:0], tail[1], tail[2]};
            3'd4:    s2_cp_next = {10'd0, s1_info_reg.payload[2:0], tail[1], tail[2],
                                   tail[3]};
            3'd5:    s2_cp_next = {5'd0, s1_info_reg.payload[1:0], tail[1], tail[2],
                                   tail[3], tail[4]};
            3'd6:    s2_cp_next = {s1_info_reg.payload[0], tail[1], tail[2], tail[3],
                                   tail[4], tail[5]};
            default: s2_cp_next = '0;
        endcase
    end

    always_comb
    begin
        priority if (s1_status_reg != ST_OK)
        begin
            s2_status_next = s1_status_reg;
        end
        else if (cont_bad || overlong)
        begin
            s2_status_next = ST_ILSEQ;
        end
        else
        begin
            s2_status_next = ST_OK;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_ready && s_tvalid)
        begin
            s1_info_reg   <= lead_info;
            s1_status_reg <= s1_status_next;
            for (int i = 1; i < WINDOW_BYTES; i++)
            begin
                s1_bytes_reg[i] <= in_bytes[i];
            end
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_status_reg <= s2_status_next;
            s2_cp_reg     <= s2_cp_next;
            s2_len_reg    <= s1_info_reg.len;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_status_reg <= s2_status_reg;
            s3_cp_reg     <= (s2_status_reg == ST_OK) ? s2_cp_reg : '0;
            s3_len_reg    <= (s2_status_reg == ST_OK) ? s2_len_reg : '0;
        end
    end

    // Output word.
    assign m_tvalid = s3_valid_reg;
    assign m_tdata  = {6'd0, s3_len_reg, s3_cp_reg};
    assign m_tuser  = s3_status_reg;

endmodule

### design/usd_checker.sv
// Port-level checks for the UTF-8 sequence decoder, bound to the top level.
`timescale 1ns / 1ps

module usd_checker
    import usd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]            m_tuser
);

    // A stalled output word stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // A successful decode consumes one to six bytes.
    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_OK) |->
            (m_tdata[33:31] != 3'd0) && (m_tdata[33:31] <= 3'd6))
        else $error("ok result with bad byte count");

    // Errors carry neither a code point nor a byte count.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[33:0] == 34'd0))
        else $error("error result with nonzero payload");

    // A one-byte sequence is plain ASCII.
    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_OK) && (m_tdata[33:31] == 3'd1) |->
            (m_tdata[30:7] == 24'd0))
        else $error("one-byte result above ASCII range");

    // With the output empty, the whole pipeline has room for a new word.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    // An offered input word is only ever held back by a full pipeline.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without an output stall");

endmodule

bind utf8_sequence_decoder_unit usd_checker u_usd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### sim/tb_top.sv
// Self-checking testbench for the UTF-8 sequence decoder unit.
`timescale 1ns / 1ps

module tb_top
    import usd_pkg::*;
();

    // One decoded result as it leaves the block.
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        status_t          st;
    } decode_t;

    // One directed window, with an optional hand-written result.
    typedef struct packed {
        logic [IN_DATA_W-1:0] word;
        logic                 pinned;
        decode_t              want;
    } window_row_t;

    localparam int RANDOM_WINDOWS = 650;
    localparam int HOLD_CYCLES    = 60;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_WINDOWS   = 40;
    localparam int MAX_REPORTS    = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    decode_t     expected_decodes[$];
    window_row_t directed_rows[$];
    bit          hold_req;
    bit          hold_done;
    int          burst_left;
    int          fail_count;
    int          windows_sent;
    int          ok_seen;
    int          ilseq_seen;
    int          toofew_seen;
    decode_t     got_word;
    decode_t     want_word;

    utf8_sequence_decoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the handshake locks up.
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Expected decode of one window, bit for bit.
    function automatic decode_t decode_window(input logic [IN_DATA_W-1:0] word);
        decode_t          res;
        logic [7:0]       lead;
        logic [7:0]       cont;
        logic [2:0]       avail;
        logic [7:0]       floor;
        logic [CP_W-1:0]  acc;
        int unsigned      seq_len;
        int unsigned      i;
        res   = '{cp: '0, len: '0, st: ST_OK};
        lead  = word[7:0];
        avail = (word[50:48] > 3'd6) ? 3'd6 : word[50:48];
        floor = MIN_SECOND_ANY;
        if (avail == 3'd0)
        begin
            res.st = ST_TOOFEW;
            return res;
        end
        // The lead byte sets the length, its payload bits and the overlong bound.
        if (lead < 8'h80)
        begin
            res.cp  = {23'd0, lead};
            res.len = 3'd1;
            return res;
        end
        else if (lead < LEAD_2B_MIN || lead >= LEAD_BAD)
        begin
            res.st = ST_ILSEQ;
            return res;
        end
        else if (lead < LEAD_3B_MIN)
        begin
            seq_len = 2;
            acc     = {26'd0, lead[4:0]};
        end
        else if (lead < LEAD_4B_MIN)
        begin
            seq_len = 3;
            acc     = {27'd0, lead[3:0]};
            if (lead == LEAD_3B_MIN)
                floor = MIN_SECOND_3B;
        end
        else if (lead < LEAD_5B_MIN)
        begin
            seq_len = 4;
            acc     = {28'd0, lead[2:0]};
            if (lead == LEAD_4B_MIN)
                floor = MIN_SECOND_4B;
        end
        else if (lead < LEAD_6B_MIN)
        begin
            seq_len = 5;
            acc     = {29'd0, lead[1:0]};
            if (lead == LEAD_5B_MIN)
                floor = MIN_SECOND_5B;
        end
        else
        begin
            seq_len = 6;
            acc     = {30'd0, lead[0]};
            if (lead == LEAD_6B_MIN)
                floor = MIN_SECOND_6B;
        end
        // A short window is reported before any continuation byte is looked at.
        if (avail < seq_len)
        begin
            res.st = ST_TOOFEW;
            return res;
        end
        for (i = 1; i < seq_len; i++)
        begin
            cont = word[8*i +: 8];
            if (cont[7:6] != 2'b10)
            begin
                res.st = ST_ILSEQ;
                return res;
            end
            acc = {acc[CP_W-7:0], cont[5:0]};
        end
        if (word[15:8] < floor)
        begin
            res.st = ST_ILSEQ;
            return res;
        end
        res.cp  = acc;
        res.len = seq_len[LEN_W-1:0];
        return res;
    endfunction

    // Random window: mostly well-formed sequences, then edge and broken cases.
    function automatic logic [IN_DATA_W-1:0] random_window();
        logic [5:0][7:0] b;
        logic [2:0]      cnt;
        logic [7:0]      lead_lo;
        logic [7:0]      lead_hi;
        logic [7:0]      floor;
        int unsigned     pick;
        int unsigned     seq_len;
        int unsigned     pos;
        int unsigned     i;
        for (i = 0; i < WINDOW_BYTES; i++)
            b[i] = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        // Pure noise.
        if (pick >= 90)
        begin
            cnt = 3'($urandom_range(0, 7));
            return {5'd0, cnt, b};
        end
        // Illegal lead bytes with any count.
        if (pick >= 83)
        begin
            b[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(254, 255))
                                               : 8'($urandom_range(128, 193));
            cnt  = 3'($urandom_range(0, 7));
            return {5'd0, cnt, b};
        end
        seq_len = $urandom_range(1, 6);
        floor   = MIN_SECOND_ANY;
        unique case (seq_len)
            1: begin lead_lo = 8'h00;       lead_hi = 8'h7f; end
            2: begin lead_lo = LEAD_2B_MIN; lead_hi = 8'hdf; end
            3: begin lead_lo = LEAD_3B_MIN; lead_hi = 8'hef; floor = MIN_SECOND_3B; end
            4: begin lead_lo = LEAD_4B_MIN; lead_hi = 8'hf7; floor = MIN_SECOND_4B; end
            5: begin lead_lo = LEAD_5B_MIN; lead_hi = 8'hfb; floor = MIN_SECOND_5B; end
            default: begin lead_lo = LEAD_6B_MIN; lead_hi = 8'hfd; floor = MIN_SECOND_6B; end
        endcase
        b[0] = 8'($urandom_range(lead_lo, lead_hi));
        for (i = 1; i < seq_len; i++)
            b[i] = 8'h80 | 8'($urandom_range(0, 63));
        cnt = 3'($urandom_range(seq_len, 7));
        if (pick < 55)
        begin
            // Well-formed; now and then on the shortest lead of its length.
            if (seq_len > 1 && $urandom_range(0, 3) == 0)
            begin
                b[0] = lead_lo;
                b[1] = 8'($urandom_range(floor, 8'hbf));
            end
        end
        else if (pick < 65)
        begin
            // Second byte right at or just below the overlong bound.
            if (seq_len > 1)
            begin
                b[0] = lead_lo;
                b[1] = floor - 8'($urandom_range(0, 1));
            end
        end
        else if (pick < 75)
        begin
            // One continuation byte outside 0x80..0xBF.
            if (seq_len > 1)
            begin
                pos    = $urandom_range(1, seq_len - 1);
                b[pos] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                                     : 8'($urandom_range(192, 255));
            end
        end
        else
        begin
            // Window shorter than the lead byte asks for.
            cnt = 3'($urandom_range(0, seq_len - 1));
        end
        return {5'd0, cnt, b};
    endfunction

    // Adds one row to the directed table.
    task automatic add_row(input int cnt, input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3,
                           input logic [7:0] b4, input logic [7:0] b5,
                           input logic pinned, input logic [CP_W-1:0] cp,
                           input int len, input status_t st);
        window_row_t r;
        r.word   = {5'd0, 3'(cnt), b5, b4, b3, b2, b1, b0};
        r.pinned = pinned;
        r.want   = '{cp: cp, len: LEN_W'(len), st: st};
        directed_rows.push_back(r);
    endtask

    // Offers one word and waits until the block takes it.
    task automatic send_word(input logic [IN_DATA_W-1:0] word);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        windows_sent++;
    endtask

    // Idle cycles on the input side, with junk on the data lines.
    task automatic idle_input(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= IN_DATA_W'({$urandom, $urandom});
        end
    endtask

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic pace();
        if (hold_req && !hold_done)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            idle_input($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Logs one failure, with details for the first few.
    task automatic report_failure(input string what, input decode_t want,
                                  input decode_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t %s: expected cp=%h len=%0d st=%0d, got cp=%h len=%0d st=%0d",
                     $realtime, what, want.cp, want.len, want.st,
                     got.cp, got.len, got.st);
    endtask

    // Receiver: a stall pattern of its own, plus one long hold-off on request.
    initial
    begin
        int unsigned period;
        int unsigned low_len;
        int unsigned phase_left;
        int unsigned tick;
        period     = 1;
        low_len    = 0;
        phase_left = 0;
        tick       = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    period     = $urandom_range(1, 8);
                    low_len    = ($urandom_range(0, 2) == 0) ? 0
                                                             : $urandom_range(0, period - 1);
                    phase_left = $urandom_range(10, 60);
                end
                phase_left--;
                m_tready <= ((tick % period) >= low_len);
                tick++;
            end
        end
    end

    // Output check: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_word.cp  = m_tdata[CP_W-1:0];
            got_word.len = m_tdata[CP_W+LEN_W-1:CP_W];
            got_word.st  = status_t'(m_tuser);
            if (expected_decodes.size() == 0)
                report_failure("unexpected result", '0, got_word);
            else
            begin
                want_word = expected_decodes.pop_front();
                unique case (want_word.st)
                    ST_OK:    ok_seen++;
                    ST_ILSEQ: ilseq_seen++;
                    default:  toofew_seen++;
                endcase
                if (got_word.cp !== want_word.cp || got_word.len !== want_word.len ||
                    got_word.st !== want_word.st)
                    report_failure("mismatch", want_word, got_word);
            end
        end
    end

    // Main sequence: reset, directed table, random windows, drain.
    initial
    begin
        logic [IN_DATA_W-1:0] word;
        int                   waited;
        hold_req     = 1'b0;
        burst_left   = 0;
        fail_count   = 0;
        windows_sent = 0;
        ok_seen      = 0;
        ilseq_seen   = 0;
        toofew_seen  = 0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: extremes, every lead class, the special cases.
        add_row(1, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 1, 'h0, 1, ST_OK);
        add_row(1, 'h7f, 'hff, 'hff, 'hff, 'hff, 'hff, 1, 'h7f, 1, ST_OK);
        add_row(6, 'h80, 'h80, 'h80, 'h80, 'h80, 'h80, 1, 0, 0, ST_ILSEQ);
        add_row(1, 'hbf, 'h00, 'h00, 'h00, 'h00, 'h00, 1, 0, 0, ST_ILSEQ);
        add_row(1, 'hc0, 'h80, 'h00, 'h00, 'h00, 'h00, 1, 0, 0, ST_ILSEQ);
        add_row(2, 'hc1, 'hbf, 'h00, 'h00, 'h00, 'h00, 1, 0, 0, ST_ILSEQ);
        add_row(6, 'hfe, 'h80, 'h80, 'h80, 'h80, 'h80, 1, 0, 0, ST_ILSEQ);
        add_row(7, 'hff, 'hbf, 'hbf, 'hbf, 'hbf, 'hbf, 1, 0, 0, ST_ILSEQ);
        add_row(0, 'h41, 'h00, 'h00, 'h00, 'h00, 'h00, 1, 0, 0, ST_TOOFEW);
        add_row(0, 'hff, 'hff, 'hff, 'hff, 'hff, 'hff, 1, 0, 0, ST_TOOFEW);
        add_row(2, 'hc2, 'h80, 'h00, 'h00, 'h00, 'h00, 1, 'h80, 2, ST_OK);
        add_row(2, 'hdf, 'hbf, 'hff, 'hff, 'hff, 'hff, 1, 'h7ff, 2, ST_OK);
        add_row(3, 'he0, 'ha0, 'h80, 'h00, 'h00, 'h00, 1, 'h800, 3, ST_OK);
        add_row(3, 'he0, 'h9f, 'hbf, 'h00, 'h00, 'h00, 1, 0, 0, ST_ILSEQ);
        add_row(3, 'hef, 'hbf, 'hbf, 'h00, 'h00, 'h00, 1, 'hffff, 3, ST_OK);
        add_row(4, 'hf0, 'h90, 'h80, 'h80, 'h00, 'h00, 1, 'h10000, 4, ST_OK);
        add_row(4, 'hf0, 'h8f, 'hbf, 'hbf, 'h00, 'h00, 1, 0, 0, ST_ILSEQ);
        add_row(4, 'hf7, 'hbf, 'hbf, 'hbf, 'h00, 'h00, 1, 'h1fffff, 4, ST_OK);
        add_row(5, 'hf8, 'h88, 'h80, 'h80, 'h80, 'h00, 1, 'h200000, 5, ST_OK);
        add_row(5, 'hf8, 'h87, 'hbf, 'hbf, 'hbf, 'h00, 1, 0, 0, ST_ILSEQ);
        add_row(6, 'hfc, 'h84, 'h80, 'h80, 'h80, 'h80, 1, 'h4000000, 6, ST_OK);
        add_row(6, 'hfc, 'h83, 'hbf, 'hbf, 'hbf, 'hbf, 1, 0, 0, ST_ILSEQ);
        add_row(7, 'hfd, 'hbf, 'hbf, 'hbf, 'hbf, 'hbf, 1, 'h7fffffff, 6, ST_OK);
        add_row(2, 'hf0, 'h8f, 'hbf, 'hbf, 'h00, 'h00, 1, 0, 0, ST_TOOFEW);
        add_row(3, 'he4, 'h38, 'had, 'h00, 'h00, 'h00, 1, 0, 0, ST_ILSEQ);
        add_row(6, 'he4, 'hb8, 'had, 'h5a, 'hff, 'h00, 0, 0, 0, ST_OK);
        add_row(5, 'hf4, 'h8f, 'hbf, 'h7f, 'h80, 'h80, 0, 0, 0, ST_OK);

        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].word);
            expected_decodes.push_back(directed_rows[i].pinned ? directed_rows[i].want
                                       : decode_window(directed_rows[i].word));
            pace();
        end

        // Random windows; partway through the receiver holds off for a long stretch.
        for (int k = 0; k < RANDOM_WINDOWS; k++)
        begin
            if (k == HOLD_AT)
                hold_req = 1'b1;
            word = random_window();
            send_word(word);
            expected_decodes.push_back(decode_window(word));
            if (k < HOLD_AT || k >= HOLD_AT + HOLD_WINDOWS)
                pace();
        end
        idle_input(1);

        // Drain the pipeline, then keep watching the output for stray results.
        waited = 0;
        while (expected_decodes.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10)
            @(posedge clk);
        while (expected_decodes.size() != 0)
            report_failure("missing result", expected_decodes.pop_front(), '0);

        $display("Sent %0d windows (%0d directed); results checked: %0d ok, %0d illegal, %0d short.",
                 windows_sent, directed_rows.size(), ok_seen, ilseq_seen, toofew_seen);
        $display("Failures: %0d, including one long output stall with a full pipeline.",
                 fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
design/usd_pkg.sv
design/usd_lead_classifier.sv
design/utf8_sequence_decoder_unit.sv
design/usd_checker.sv
sim/tb_top.sv
